// ===== rtl/arpc_pkg.sv =====
// shared constants, types and state encoding for the arp cache responder
package arpc_pkg;

    localparam int          CACHE_ENTRIES_DEF = 16;
    localparam int          PADDR_W           = 4;
    localparam int          PDATA_W           = 64;

    localparam logic [31:0] HOST_IP_RST       = 32'h0A00_020F;
    localparam logic [47:0] LOCAL_MAC_RST     = 48'h0;

    localparam logic [15:0] HW_ETHERNET       = 16'h0001;
    localparam logic [15:0] PROTO_IPV4        = 16'h0800;
    localparam logic [15:0] OP_REQUEST        = 16'h0001;

    localparam logic        REQ_LOOKUP        = 1'b0;
    localparam logic        REQ_ARP           = 1'b1;

    // register select is paddr bit 3, low bits are byte lanes
    localparam logic        REG_HOST_IP       = 1'b0;
    localparam logic        REG_LOCAL_MAC     = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } arpc_state_t;

    typedef struct packed {
        logic        hit;
        logic [47:0] resolved_mac;
        logic        accepted;
        logic        send_reply;
        logic [47:0] reply_mac;
        logic [31:0] reply_ip;
    } arpc_result_t;

endpackage

// ===== rtl/arpc_table.sv =====
// binding table: valid flops plus ip and mac memories with one read and one write port
module arpc_table #(
    parameter int ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF,
    parameter int IDX_W   = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic             rd_valid,
    output logic [31:0]      rd_ip,
    output logic [47:0]      rd_mac,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [31:0]      wr_ip,
    input  logic [47:0]      wr_mac
);

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [31:0]        ip_mem  [ENTRIES];
    logic [47:0]        mac_mem [ENTRIES];
    logic               rd_valid_reg;
    logic [31:0]        rd_ip_reg;
    logic [47:0]        rd_mac_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ip_mem[wr_addr]  <= wr_ip;
            mac_mem[wr_addr] <= wr_mac;
        end
        if (rd_en)
        begin
            rd_ip_reg  <= ip_mem[rd_addr];
            rd_mac_reg <= mac_mem[rd_addr];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_ip    = rd_ip_reg;
    assign rd_mac   = rd_mac_reg;

endmodule

// ===== rtl/arpc_seq.sv =====
// scan sequencer: walks the table once per lookup or well-typed arp packet through one shared ip compare
module arpc_seq #(
    parameter int ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF,
    parameter int IDX_W   = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [31:0]           query_ip,
    input  logic [15:0]           hw_type,
    input  logic [15:0]           ptype,
    input  logic [15:0]           arp_op,
    input  logic [31:0]           src_ip,
    input  logic [47:0]           src_mac,
    input  logic [31:0]           tgt_ip,
    input  logic [31:0]           host_ip,
    output logic                  rd_en,
    output logic [IDX_W-1:0]      rd_addr,
    input  logic                  rd_valid,
    input  logic [31:0]           rd_ip,
    input  logic [47:0]           rd_mac,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_addr,
    output logic [31:0]           wr_ip,
    output logic [47:0]           wr_mac,
    output logic                  res_valid,
    input  logic                  res_ready,
    output arpc_pkg::arpc_result_t res
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    arpc_pkg::arpc_state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             req_type_reg, req_type_next;
    logic [31:0]      key_reg, key_next;
    logic [47:0]      mac_reg, mac_next;
    logic             types_ok_reg, types_ok_next;
    logic             reply_reg, reply_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] found_idx_reg, found_idx_next;
    logic [47:0]      found_mac_reg, found_mac_next;
    logic             empty_reg, empty_next;
    logic [IDX_W-1:0] empty_idx_reg, empty_idx_next;

    logic in_types_ok;
    logic in_fire;
    logic scan_end;
    logic match;
    logic empty_seen;

    assign in_types_ok = (hw_type == arpc_pkg::HW_ETHERNET) &&
                         (ptype == arpc_pkg::PROTO_IPV4);
    assign in_fire     = in_valid && in_ready;
    assign scan_end    = (cnt_reg == CNT_W'(ENTRIES)) && !pend_reg;
    assign match       = pend_reg && rd_valid && (rd_ip == key_reg);
    assign empty_seen  = pend_reg && !rd_valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            arpc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == arpc_pkg::REQ_ARP && !in_types_ok)
                    begin
                        state_next = arpc_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = arpc_pkg::ST_SCAN;
                    end
                end
            end
            arpc_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = (req_type_reg == arpc_pkg::REQ_ARP) ?
                                 arpc_pkg::ST_WRITE : arpc_pkg::ST_DONE;
                end
            end
            arpc_pkg::ST_WRITE:
            begin
                state_next = arpc_pkg::ST_DONE;
            end
            arpc_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = arpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arpc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = (state_reg == arpc_pkg::ST_IDLE);
        rd_en     = (state_reg == arpc_pkg::ST_SCAN) && (cnt_reg < CNT_W'(ENTRIES));
        rd_addr   = cnt_reg[IDX_W-1:0];
        wr_en     = (state_reg == arpc_pkg::ST_WRITE);
        wr_ip     = key_reg;
        wr_mac    = mac_reg;
        if (found_reg)
        begin
            wr_addr = found_idx_reg;
        end
        else if (empty_reg)
        begin
            wr_addr = empty_idx_reg;
        end
        else
        begin
            wr_addr = '0;
        end
        res_valid = (state_reg == arpc_pkg::ST_DONE);
        res       = '0;
        if (req_type_reg == arpc_pkg::REQ_LOOKUP)
        begin
            res.hit          = found_reg;
            res.resolved_mac = found_reg ? found_mac_reg : 48'h0;
        end
        else
        begin
            res.accepted   = types_ok_reg;
            res.send_reply = reply_reg;
            res.reply_mac  = reply_reg ? mac_reg : 48'h0;
            res.reply_ip   = reply_reg ? key_reg : 32'h0;
        end
    end

    // datapath
    always_comb
    begin
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        req_type_next  = req_type_reg;
        key_next       = key_reg;
        mac_next       = mac_reg;
        types_ok_next  = types_ok_reg;
        reply_next     = reply_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        found_mac_next = found_mac_reg;
        empty_next     = empty_reg;
        empty_idx_next = empty_idx_reg;
        if (in_fire)
        begin
            cnt_next      = '0;
            req_type_next = req_type;
            key_next      = (req_type == arpc_pkg::REQ_ARP) ? src_ip : query_ip;
            mac_next      = src_mac;
            types_ok_next = in_types_ok;
            reply_next    = (req_type == arpc_pkg::REQ_ARP) && in_types_ok &&
                            (arp_op == arpc_pkg::OP_REQUEST) && (tgt_ip == host_ip);
            found_next    = 1'b0;
            empty_next    = 1'b0;
        end
        else if (state_reg == arpc_pkg::ST_SCAN)
        begin
            if (rd_en)
            begin
                cnt_next      = cnt_reg + CNT_W'(1);
                pend_next     = 1'b1;
                pend_idx_next = rd_addr;
            end
            if (match && !found_reg)
            begin
                found_next     = 1'b1;
                found_idx_next = pend_idx_reg;
                found_mac_next = rd_mac;
            end
            if (empty_seen && !empty_reg)
            begin
                empty_next     = 1'b1;
                empty_idx_next = pend_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arpc_pkg::ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            empty_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        req_type_reg  <= req_type_next;
        key_reg       <= key_next;
        mac_reg       <= mac_next;
        types_ok_reg  <= types_ok_next;
        reply_reg     <= reply_next;
        found_idx_reg <= found_idx_next;
        found_mac_reg <= found_mac_next;
        empty_idx_reg <= empty_idx_next;
    end

endmodule

// ===== rtl/arp_cache_responder.sv =====
// top level: config registers, table, scan sequencer and result register
//
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------
// input    | in_valid / in_ready  | req_type query_ip hw_type ptype arp_op
//          |                      | src_ip src_mac tgt_ip
// output   | out_valid / out_ready| hit resolved_mac accepted send_reply
//          |                      | reply_mac reply_ip
// config   | psel penable pwrite  | paddr pwdata prdata (host_ip 0x0, local_mac 0x8)
//
// order of states: a lookup walks the table then finishes, an arp learn adds a table write
// after the walk, and a dropped packet skips the walk and goes straight to the result
// the walk reads one entry per cycle through the table read port and ip compare
// reset clears all valid bits at once, no clearing pass
// a finished result waits in the output register; the next transaction is taken meanwhile
// and holds in its last cycle until the output register is free
module arp_cache_responder #(
    parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [arpc_pkg::PADDR_W-1:0]  paddr,
    input  logic [arpc_pkg::PDATA_W-1:0]  pwdata,
    output logic [arpc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [31:0]                   query_ip,
    input  logic [15:0]                   hw_type,
    input  logic [15:0]                   ptype,
    input  logic [15:0]                   arp_op,
    input  logic [31:0]                   src_ip,
    input  logic [47:0]                   src_mac,
    input  logic [31:0]                   tgt_ip,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic [47:0]                   resolved_mac,
    output logic                          accepted,
    output logic                          send_reply,
    output logic [47:0]                   reply_mac,
    output logic [31:0]                   reply_ip
);

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    logic [31:0]            host_ip_reg, host_ip_next;
    logic [47:0]            local_mac_reg, local_mac_next;
    logic                   out_valid_reg, out_valid_next;
    arpc_pkg::arpc_result_t out_data_reg, out_data_next;

    logic                   cfg_wr;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   rd_valid;
    logic [31:0]            rd_ip;
    logic [47:0]            rd_mac;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [31:0]            wr_ip;
    logic [47:0]            wr_mac;
    logic                   res_valid;
    logic                   res_ready;
    arpc_pkg::arpc_result_t res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        host_ip_next   = host_ip_reg;
        local_mac_next = local_mac_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3])
                arpc_pkg::REG_HOST_IP:   host_ip_next   = pwdata[31:0];
                arpc_pkg::REG_LOCAL_MAC: local_mac_next = pwdata[47:0];
                default:                 host_ip_next   = host_ip_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            arpc_pkg::REG_HOST_IP:   prdata = {32'h0, host_ip_reg};
            arpc_pkg::REG_LOCAL_MAC: prdata = {16'h0, local_mac_reg};
            default:                 prdata = '0;
        endcase
    end

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_ip_reg   <= arpc_pkg::HOST_IP_RST;
            local_mac_reg <= arpc_pkg::LOCAL_MAC_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            host_ip_reg   <= host_ip_next;
            local_mac_reg <= local_mac_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid    = out_valid_reg;
    assign hit          = out_data_reg.hit;
    assign resolved_mac = out_data_reg.resolved_mac;
    assign accepted     = out_data_reg.accepted;
    assign send_reply   = out_data_reg.send_reply;
    assign reply_mac    = out_data_reg.reply_mac;
    assign reply_ip     = out_data_reg.reply_ip;

    arpc_table #(
        .ENTRIES (CACHE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_valid (rd_valid),
        .rd_ip    (rd_ip),
        .rd_mac   (rd_mac),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_ip    (wr_ip),
        .wr_mac   (wr_mac)
    );

    arpc_seq #(
        .ENTRIES (CACHE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .query_ip   (query_ip),
        .hw_type    (hw_type),
        .ptype      (ptype),
        .arp_op     (arp_op),
        .src_ip     (src_ip),
        .src_mac    (src_mac),
        .tgt_ip     (tgt_ip),
        .host_ip    (host_ip_reg),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_valid   (rd_valid),
        .rd_ip      (rd_ip),
        .rd_mac     (rd_mac),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_ip      (wr_ip),
        .wr_mac     (wr_mac),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule

// ===== tb/arp_cache_responder_tb.sv =====
// testbench for arp_cache_responder: directed and random transactions checked by a table model
`timescale 1ns / 100ps

module arp_cache_responder_tb;

    localparam int          ENTRIES      = arpc_pkg::CACHE_ENTRIES_DEF;
    localparam int          SETTLE_CYCLES = 2 * (ENTRIES + 4);
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          PHASE_ITEMS  = 560;
    localparam logic [15:0] OP_REPLY     = 16'h0002;

    localparam logic [arpc_pkg::PADDR_W-1:0] ADDR_HOST_IP   = {arpc_pkg::REG_HOST_IP, 3'b000};
    localparam logic [arpc_pkg::PADDR_W-1:0] ADDR_LOCAL_MAC = {arpc_pkg::REG_LOCAL_MAC, 3'b000};

    typedef struct {
        logic        req_type;
        logic [31:0] query_ip;
        logic [15:0] hw_type;
        logic [15:0] ptype;
        logic [15:0] arp_op;
        logic [31:0] src_ip;
        logic [47:0] src_mac;
        logic [31:0] tgt_ip;
    } arp_request_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [arpc_pkg::PADDR_W-1:0]  paddr = '0;
    logic [arpc_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [arpc_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          req_type = 1'b0;
    logic [31:0]                   query_ip = '0;
    logic [15:0]                   hw_type = '0;
    logic [15:0]                   ptype = '0;
    logic [15:0]                   arp_op = '0;
    logic [31:0]                   src_ip = '0;
    logic [47:0]                   src_mac = '0;
    logic [31:0]                   tgt_ip = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          hit;
    logic [47:0]                   resolved_mac;
    logic                          accepted;
    logic                          send_reply;
    logic [47:0]                   reply_mac;
    logic [31:0]                   reply_ip;

    // model of the cache and registers
    logic                          model_valid [ENTRIES];
    logic [31:0]                   model_ip [ENTRIES];
    logic [47:0]                   model_mac [ENTRIES];
    logic [31:0]                   model_host_ip = arpc_pkg::HOST_IP_RST;

    arp_request_t                  request_q [$];
    arpc_pkg::arpc_result_t        pending_answers [$];
    logic [31:0]                   learned_ips [$];
    arp_request_t                  taken_request;
    arp_request_t                  next_request;
    arpc_pkg::arpc_result_t        oldest_answer;
    int                            send_idle_pct = 16;
    int                            recv_idle_pct = 61;
    int                            cycle_count = 0;
    bit                            failed = 1'b0;

    arp_cache_responder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .query_ip     (query_ip),
        .hw_type      (hw_type),
        .ptype        (ptype),
        .arp_op       (arp_op),
        .src_ip       (src_ip),
        .src_mac      (src_mac),
        .tgt_ip       (tgt_ip),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .resolved_mac (resolved_mac),
        .accepted     (accepted),
        .send_reply   (send_reply),
        .reply_mac    (reply_mac),
        .reply_ip     (reply_ip)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            model_valid[i] = 1'b0;
        end
    end

    function automatic int find_entry(input logic [31:0] ip);
        int slot;
        slot = ENTRIES;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (model_valid[i] && model_ip[i] == ip)
                slot = i;
        end
        return slot;
    endfunction

    function automatic arpc_pkg::arpc_result_t answer_request(input arp_request_t rq);
        arpc_pkg::arpc_result_t ans;
        int                     slot;
        ans = '0;
        if (rq.req_type == arpc_pkg::REQ_LOOKUP)
        begin
            slot = find_entry(rq.query_ip);
            if (slot < ENTRIES)
            begin
                ans.hit = 1'b1;
                ans.resolved_mac = model_mac[slot];
            end
        end
        else if (rq.hw_type == arpc_pkg::HW_ETHERNET && rq.ptype == arpc_pkg::PROTO_IPV4)
        begin
            slot = find_entry(rq.src_ip);
            // lowest empty slot, slot 0 when the table is full
            if (slot == ENTRIES)
            begin
                slot = 0;
                for (int i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (!model_valid[i])
                        slot = i;
                end
            end
            model_valid[slot] = 1'b1;
            model_ip[slot] = rq.src_ip;
            model_mac[slot] = rq.src_mac;
            ans.accepted = 1'b1;
            if (rq.arp_op == arpc_pkg::OP_REQUEST && rq.tgt_ip == model_host_ip)
            begin
                ans.send_reply = 1'b1;
                ans.reply_mac = rq.src_mac;
                ans.reply_ip = rq.src_ip;
            end
        end
        return ans;
    endfunction

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic arp_request_t blank_request();
        arp_request_t rq;
        rq.req_type = arpc_pkg::REQ_LOOKUP;
        rq.query_ip = '0;
        rq.hw_type = '0;
        rq.ptype = '0;
        rq.arp_op = '0;
        rq.src_ip = '0;
        rq.src_mac = '0;
        rq.tgt_ip = '0;
        return rq;
    endfunction

    function automatic void push_lookup(input logic [31:0] ip);
        arp_request_t rq;
        rq = blank_request();
        rq.query_ip = ip;
        request_q.push_back(rq);
    endfunction

    function automatic void push_arp(input logic [15:0] hw, input logic [15:0] proto,
                                     input logic [15:0] op, input logic [31:0] sip,
                                     input logic [47:0] smac, input logic [31:0] tip);
        arp_request_t rq;
        rq = blank_request();
        rq.req_type = arpc_pkg::REQ_ARP;
        rq.hw_type = hw;
        rq.ptype = proto;
        rq.arp_op = op;
        rq.src_ip = sip;
        rq.src_mac = smac;
        rq.tgt_ip = tip;
        if (hw == arpc_pkg::HW_ETHERNET && proto == arpc_pkg::PROTO_IPV4)
            learned_ips.push_back(sip);
        request_q.push_back(rq);
    endfunction

    function automatic arp_request_t gen_random_request();
        arp_request_t rq;
        int           pick;
        rq.req_type = arpc_pkg::REQ_LOOKUP;
        rq.query_ip = $urandom;
        rq.hw_type = 16'($urandom);
        rq.ptype = 16'($urandom);
        rq.arp_op = 16'($urandom);
        rq.src_ip = $urandom;
        rq.src_mac = rand_mac();
        rq.tgt_ip = $urandom;
        if ($urandom_range(99) < 40)
        begin
            if ($urandom_range(99) < 75)
                rq.query_ip = learned_ips[$urandom_range(learned_ips.size() - 1)];
        end
        else
        begin
            rq.req_type = arpc_pkg::REQ_ARP;
            pick = $urandom_range(99);
            // mostly well-formed frames, some with one or both type fields bad
            if (pick < 85)
            begin
                rq.hw_type = arpc_pkg::HW_ETHERNET;
                rq.ptype = arpc_pkg::PROTO_IPV4;
            end
            else if (pick < 92)
                rq.hw_type = arpc_pkg::HW_ETHERNET;
            else if (pick < 98)
                rq.ptype = arpc_pkg::PROTO_IPV4;
            pick = $urandom_range(99);
            if (pick < 45)
                rq.arp_op = arpc_pkg::OP_REQUEST;
            else if (pick < 80)
                rq.arp_op = OP_REPLY;
            pick = $urandom_range(99);
            if (pick < 60)
                rq.tgt_ip = model_host_ip;
            else if (pick < 75)
                rq.tgt_ip = learned_ips[$urandom_range(learned_ips.size() - 1)];
            if ($urandom_range(99) < 60)
                rq.src_ip = learned_ips[$urandom_range(learned_ips.size() - 1)];
            if ($urandom_range(99) < 5)
                rq.src_mac = '0;
            if (rq.hw_type == arpc_pkg::HW_ETHERNET && rq.ptype == arpc_pkg::PROTO_IPV4)
            begin
                learned_ips.push_back(rq.src_ip);
                if (learned_ips.size() > 48)
                    void'(learned_ips.pop_front());
            end
        end
        return rq;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    task automatic write_reg(input logic [arpc_pkg::PADDR_W-1:0] addr,
                             input logic [arpc_pkg::PDATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_HOST_IP)
            model_host_ip = data[31:0];
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || in_valid || pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                taken_request.req_type = req_type;
                taken_request.query_ip = query_ip;
                taken_request.hw_type = hw_type;
                taken_request.ptype = ptype;
                taken_request.arp_op = arp_op;
                taken_request.src_ip = src_ip;
                taken_request.src_mac = src_mac;
                taken_request.tgt_ip = tgt_ip;
                pending_answers.push_back(answer_request(taken_request));
            end
            if (!in_valid || in_ready)
            begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_request = request_q.pop_front();
                    in_valid <= 1'b1;
                    req_type <= next_request.req_type;
                    query_ip <= next_request.query_ip;
                    hw_type <= next_request.hw_type;
                    ptype <= next_request.ptype;
                    arp_op <= next_request.arp_op;
                    src_ip <= next_request.src_ip;
                    src_mac <= next_request.src_mac;
                    tgt_ip <= next_request.tgt_ip;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("result transaction with no request outstanding");
                    failed = 1'b1;
                end
                else
                begin
                    oldest_answer = pending_answers.pop_front();
                    compare_field("hit", 64'(oldest_answer.hit), 64'(hit));
                    compare_field("resolved_mac", 64'(oldest_answer.resolved_mac),
                                  64'(resolved_mac));
                    compare_field("accepted", 64'(oldest_answer.accepted), 64'(accepted));
                    compare_field("send_reply", 64'(oldest_answer.send_reply),
                                  64'(send_reply));
                    compare_field("reply_mac", 64'(oldest_answer.reply_mac), 64'(reply_mac));
                    compare_field("reply_ip", 64'(oldest_answer.reply_ip), 64'(reply_ip));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** arp_cache_responder: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] ip_setting;
        logic [47:0] mac_setting;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, bad types, zero addresses, update of a held entry
        push_lookup(32'h0000_0000);
        push_arp(16'h0000, arpc_pkg::PROTO_IPV4, arpc_pkg::OP_REQUEST, 32'h0A00_0001,
                 rand_mac(), model_host_ip);
        push_arp(16'hFFFF, 16'h0000, arpc_pkg::OP_REQUEST, 32'h0A00_0002, rand_mac(),
                 model_host_ip);
        push_arp(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4, arpc_pkg::OP_REQUEST,
                 32'h0000_0000, 48'h0, model_host_ip);
        push_lookup(32'h0000_0000);
        push_arp(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4, OP_REPLY, 32'hFFFF_FFFF,
                 48'hFFFF_FFFF_FFFF, model_host_ip);
        push_arp(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4, arpc_pkg::OP_REQUEST,
                 32'h0000_0000, 48'h0000_1234_5678, ~model_host_ip);
        push_lookup(32'hFFFF_FFFF);
        // fill the table, then one more learn overwrites slot 0
        for (int k = 0; k < ENTRIES - 1; k++)
        begin
            push_arp(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                     (k % 3 == 0) ? arpc_pkg::OP_REQUEST :
                     ((k % 3 == 1) ? 16'hFFFF : 16'h0000),
                     32'hC0A8_0100 + k, rand_mac(), model_host_ip);
        end
        push_lookup(32'h0000_0000);
        push_lookup(32'hC0A8_0100 + ENTRIES - 2);
        wait_idle();

        for (int phase = 1; phase <= 3; phase++)
        begin
            case (phase)
                1:
                begin
                    ip_setting = 32'h0000_0000;
                    mac_setting = 48'hFFFF_FFFF_FFFF;
                    send_idle_pct = 16;
                    recv_idle_pct = 61;
                end
                2:
                begin
                    ip_setting = 32'hFFFF_FFFF;
                    mac_setting = 48'h0;
                    send_idle_pct = 61;
                    recv_idle_pct = 16;
                end
                default:
                begin
                    ip_setting = $urandom;
                    mac_setting = rand_mac();
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_reg(ADDR_HOST_IP, {32'h0, ip_setting});
            write_reg(ADDR_LOCAL_MAC, {16'h0, mac_setting});
            repeat (PHASE_ITEMS) request_q.push_back(gen_random_request());
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (!failed && pending_answers.size() == 0)
            $display("** arp_cache_responder: PASSED **");
        else
            $display("** arp_cache_responder: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/arpc_pkg.sv
rtl/arpc_table.sv
rtl/arpc_seq.sv
rtl/arp_cache_responder.sv
tb/arp_cache_responder_tb.sv
